@@ rtl/core/nrss_pkg.sv @@
// Shared types, widths and codes for the nearest request seek scheduler.
package nrss_pkg;

    localparam int NUM_POSITIONS = 1024;
    localparam int COUNT_BITS    = 16;

    localparam int POS_W    = 10;
    localparam int STATUS_W = 2;
    localparam int SUM_W    = 32;
    localparam int PEND_W   = 20;
    localparam int POS_BITS = $clog2(NUM_POSITIONS);
    localparam int K_W      = POS_BITS + 1;
    localparam int SCAN_W   = ((POS_BITS > POS_W) ? POS_BITS : POS_W) + 1;

    localparam logic [POS_W-1:0]      TRACK_END_RST = POS_W'(1023);
    localparam logic [COUNT_BITS-1:0] CNT_MAX       = {COUNT_BITS{1'b1}};
    localparam logic [PEND_W-1:0]     PEND_MAX      = {PEND_W{1'b1}};
    localparam logic [SUM_W-1:0]      SUM_MAX       = {SUM_W{1'b1}};
    localparam logic [SCAN_W-1:0]     LAST_POS      = SCAN_W'(NUM_POSITIONS - 1);

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_SERVE = 1'b1;

    localparam logic [STATUS_W-1:0] STS_ADDED    = 2'd0;
    localparam logic [STATUS_W-1:0] STS_SERVED   = 2'd1;
    localparam logic [STATUS_W-1:0] STS_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] STS_REJECTED = 2'd3;

    typedef struct packed {
        logic             op;
        logic [POS_W-1:0] position;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    head_position;
        logic [POS_W-1:0]    distance_moved;
        logic [SUM_W-1:0]    total_distance;
    } t_result;

    typedef struct packed {
        logic clear;
        logic load;
        logic add_commit;
        logic scan;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_done;
        logic is_serve;
        logic scan_found;
        logic scan_none;
    } t_dp_stat;

endpackage

@@ rtl/core/nearest_request_seek_scheduler_top.sv @@
// Top level of the nearest request seek scheduler.
//
// Usage:
//  - Request channel: drive i_req and raise start; the request is taken at a
//    rising edge where start is high and busy is low. op = add places one
//    pending request at i_req.position; op = serve moves the head to the
//    nearest pending request (ties go the last direction of travel).
//  - Result channel: o_strobe is high for exactly one cycle with o_result.
//    There is no backpressure; the receiver must take it in that cycle.
//  - Config: i_cfg_we / i_cfg_data write track_end at any edge; write it only
//    while the block is idle.
//  - Serve scans out to distance d, where d is the distance to the served
//    request, or the farther probe limit when nothing is pending. The
//    scan probes both sides of the head at one distance per cycle through
//    the dual read port of the count RAM, one pipelined read ahead.
//  - busy drops in the cycle the result strobe shows, so a new request can
//    be taken then.
//  - Reset: a clearing pass zeroes all NUM_POSITIONS = 1024 entries of the
//    count RAM, one entry per cycle, with busy high; head = 0, direction
//    right, total distance 0, track_end = 1023.
module nearest_request_seek_scheduler_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  nrss_pkg::t_req             i_req,
    input  logic                       i_cfg_we,
    input  logic [nrss_pkg::POS_W-1:0] i_cfg_data,
    output logic                       o_strobe,
    output nrss_pkg::t_result          o_result
);
    import nrss_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencer: owns busy and steps the datapath.
    nrss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Count RAM, head state, scan pipeline and result register.
    nrss_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

endmodule

@@ rtl/core/nrss_ram.sv @@
// Generic single write, dual read RAM with registered read data.
module nrss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

@@ rtl/core/nrss_ctrl.sv @@
// Sequencer: clearing pass, request decode, add update and outward scan.
module nrss_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  nrss_pkg::t_dp_stat i_stat,
    output nrss_pkg::t_dp_cmd  o_cmd
);
    import nrss_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_LOAD   = 3'd2;
    localparam logic [2:0] S_ADD_WR = 3'd3;
    localparam logic [2:0] S_SCAN   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.load = start;
                if (start) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = i_stat.is_serve ? S_SCAN : S_ADD_WR;
            end
            S_ADD_WR: begin
                o_cmd.add_commit = 1'b1;
                n_state          = S_IDLE;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_found || i_stat.scan_none) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

@@ rtl/core/nrss_dpath.sv @@
// Datapath: count store, head state, scan pipeline and result register.
module nrss_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  nrss_pkg::t_dp_cmd           i_cmd,
    output nrss_pkg::t_dp_stat          o_stat,
    input  nrss_pkg::t_req              i_req,
    input  logic                        i_cfg_we,
    input  logic [nrss_pkg::POS_W-1:0]  i_cfg_data,
    output logic                        o_strobe,
    output nrss_pkg::t_result           o_result
);
    import nrss_pkg::*;

    // Registers
    logic [POS_W-1:0]      r_track_end;
    logic                  r_op;
    logic [POS_W-1:0]      r_pos;
    logic [POS_BITS-1:0]   r_head;
    logic                  r_right;
    logic [PEND_W-1:0]     r_ptotal;
    logic [SUM_W-1:0]      r_sum;
    logic [K_W-1:0]        r_k;
    logic [K_W-1:0]        r_kd;
    logic                  r_lvd;
    logic                  r_rvd;
    logic                  r_evalv;
    logic [POS_BITS-1:0]   r_clr_addr;
    logic                  r_strobe;
    t_result               r_out;

    // Next values
    logic [POS_BITS-1:0]   n_head;
    logic                  n_right;
    logic [PEND_W-1:0]     n_ptotal;
    logic [SUM_W-1:0]      n_sum;
    logic                  n_strobe;
    t_result               n_out;

    // Combinational
    logic [SCAN_W-1:0]     end_w;
    logic [SCAN_W-1:0]     head_w;
    logic [SCAN_W-1:0]     k_w;
    logic [SCAN_W-1:0]     kd_w;
    logic [SCAN_W-1:0]     pos_w;
    logic                  lv;
    logic                  rv;
    logic                  lh;
    logic                  rh;
    logic                  take_right;
    logic                  found;
    logic                  none;
    logic                  in_range;
    logic [POS_BITS-1:0]   target;
    logic [COUNT_BITS-1:0] tgt_cnt;
    logic [SUM_W:0]        sum_ext;
    logic                  we;
    logic [POS_BITS-1:0]   waddr;
    logic [COUNT_BITS-1:0] wdata;
    logic [POS_BITS-1:0]   raddr_a;
    logic [POS_BITS-1:0]   raddr_b;
    logic [COUNT_BITS-1:0] rd_a;
    logic [COUNT_BITS-1:0] rd_b;

    // Line end clamped to the store.
    assign end_w  = (SCAN_W'(r_track_end) > LAST_POS) ? LAST_POS : SCAN_W'(r_track_end);
    assign head_w = SCAN_W'(r_head);
    assign k_w    = SCAN_W'(r_k);
    assign kd_w   = SCAN_W'(r_kd);
    assign pos_w  = SCAN_W'(r_pos);

    // Issue side of the scan: both probes at distance k.
    assign lv      = (head_w >= k_w);
    assign rv      = ((head_w + k_w) <= end_w);
    assign raddr_a = i_cmd.scan ? POS_BITS'(head_w - k_w) : POS_BITS'(pos_w);
    assign raddr_b = POS_BITS'(head_w + k_w);

    // Evaluate side: read data for distance r_kd.
    assign lh         = r_lvd && (rd_a != '0);
    assign rh         = r_rvd && (rd_b != '0);
    assign take_right = rh && (!lh || r_right);
    assign found      = i_cmd.scan && r_evalv && (lh || rh);
    assign none       = i_cmd.scan && r_evalv && !r_lvd && !r_rvd;
    assign target     = take_right ? POS_BITS'(head_w + kd_w) : POS_BITS'(head_w - kd_w);
    assign tgt_cnt    = take_right ? rd_b : rd_a;
    assign sum_ext    = {1'b0, r_sum} + (SUM_W+1)'(r_kd);

    assign in_range = (pos_w <= end_w);

    // Single write port: clear sweep, add increment, serve decrement.
    always_comb begin
        we    = 1'b0;
        waddr = r_clr_addr;
        wdata = '0;
        if (i_cmd.clear) begin
            we = 1'b1;
        end else if (i_cmd.add_commit) begin
            we    = in_range && (rd_a != CNT_MAX);
            waddr = POS_BITS'(pos_w);
            wdata = rd_a + COUNT_BITS'(1);
        end else if (found) begin
            we    = 1'b1;
            waddr = target;
            wdata = tgt_cnt - COUNT_BITS'(1);
        end
    end

    nrss_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_POSITIONS)
    ) u_cnt_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .o_rdata_a (rd_a),
        .i_raddr_b (raddr_b),
        .o_rdata_b (rd_b)
    );

    always_comb begin
        n_head   = r_head;
        n_right  = r_right;
        n_ptotal = r_ptotal;
        n_sum    = r_sum;
        n_strobe = 1'b0;
        n_out    = r_out;
        if (i_cmd.add_commit) begin
            n_strobe             = 1'b1;
            n_out.status         = in_range ? STS_ADDED : STS_REJECTED;
            n_out.head_position  = POS_W'(head_w);
            n_out.distance_moved = '0;
            n_out.total_distance = r_sum;
            if (in_range && (rd_a != CNT_MAX) && (r_ptotal != PEND_MAX)) begin
                n_ptotal = r_ptotal + PEND_W'(1);
            end
        end else if (found) begin
            n_head   = target;
            n_right  = (lh && rh) ? r_right : rh;
            n_sum    = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
            if (r_ptotal != '0) begin
                n_ptotal = r_ptotal - PEND_W'(1);
            end
            n_strobe             = 1'b1;
            n_out.status         = STS_SERVED;
            n_out.head_position  = POS_W'(SCAN_W'(target));
            n_out.distance_moved = POS_W'(kd_w);
            n_out.total_distance = n_sum;
        end else if (none) begin
            n_strobe             = 1'b1;
            n_out.status         = STS_EMPTY;
            n_out.head_position  = POS_W'(head_w);
            n_out.distance_moved = '0;
            n_out.total_distance = r_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track_end <= TRACK_END_RST;
            r_head      <= '0;
            r_right     <= 1'b1;
            r_ptotal    <= '0;
            r_sum       <= '0;
            r_clr_addr  <= '0;
            r_evalv     <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_track_end <= i_cfg_data;
            end
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + POS_BITS'(1);
            end
            if (i_cmd.load) begin
                r_evalv <= 1'b0;
            end else if (i_cmd.scan) begin
                r_evalv <= 1'b1;
            end
            r_head   <= n_head;
            r_right  <= n_right;
            r_ptotal <= n_ptotal;
            r_sum    <= n_sum;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_req.op;
            r_pos <= i_req.position;
            r_k   <= '0;
        end else if (i_cmd.scan) begin
            r_k   <= r_k + K_W'(1);
            r_kd  <= r_k;
            r_lvd <= lv;
            r_rvd <= rv;
        end
        r_out <= n_out;
    end

    assign o_stat.clear_done = (r_clr_addr == POS_BITS'(NUM_POSITIONS - 1));
    assign o_stat.is_serve   = (r_op == OP_SERVE);
    assign o_stat.scan_found = found;
    assign o_stat.scan_none  = none;

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

@@ rtl/core/nrss_checker.sv @@
// Port-level checks for the seek scheduler, bound to the top level.
module nrss_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_strobe,
    input nrss_pkg::t_result o_result
);
    import nrss_pkg::*;

    // A taken request keeps the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy low right after a request was taken");

    // Results are never back to back.
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe on two consecutive cycles");

    // The block is ready again when a result shows.
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

    // Only a serve moves the head.
    a_no_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.status != STS_SERVED)) |-> (o_result.distance_moved == '0))
        else $error("nonzero distance on a result that is not a serve");

endmodule

bind nearest_request_seek_scheduler_top nrss_checker u_nrss_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

@@ tb/sv/nearest_request_seek_scheduler_checker.sv @@
// Result checker for the nearest request seek scheduler: tracks the head and pending counts.
`timescale 1ns / 100ps

module nearest_request_seek_scheduler_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_busy,
    input  nrss_pkg::t_req             i_req,
    input  logic                       i_cfg_we,
    input  logic [nrss_pkg::POS_W-1:0] i_cfg_data,
    input  logic                       i_strobe,
    input  nrss_pkg::t_result          i_result,
    output int                         o_miscompares,
    output int                         o_awaited
);
    import nrss_pkg::*;

    localparam int MAX_REPORTS = 100;

    logic [COUNT_BITS-1:0] req_count [NUM_POSITIONS];
    logic [POS_W-1:0]      head;
    logic                  moving_right;
    logic [PEND_W-1:0]     queued_total;
    logic [SUM_W-1:0]      travel_sum;
    logic [POS_W-1:0]      track_end;

    t_result awaited_outcomes[$];
    int      miscompares = 0;

    // Applies one request to the local copy of the scheduler and returns its outcome.
    function automatic t_result schedule_request(input t_req req);
        t_result res;
        int      h;
        int      end_pos;
        int      target;
        int      moved;
        bit      found;
        bit      lv, rv, lh, rh;
        res     = '0;
        h       = int'(head);
        end_pos = int'(track_end);
        if (end_pos > NUM_POSITIONS - 1)
            end_pos = NUM_POSITIONS - 1;
        target  = h;
        moved   = 0;
        found   = 1'b0;
        if (req.op == OP_ADD) begin
            if (int'(req.position) > end_pos) begin
                res.status = STS_REJECTED;
            end else begin
                res.status = STS_ADDED;
                if (req_count[req.position] != CNT_MAX) begin
                    req_count[req.position] = req_count[req.position] + COUNT_BITS'(1);
                    if (queued_total != PEND_MAX)
                        queued_total = queued_total + PEND_W'(1);
                end
            end
        end else begin
            res.status = STS_EMPTY;
            // Probe both sides outward; the left side is not bounded by track_end.
            for (int k = 0; k < NUM_POSITIONS; k++) begin
                lv = (h >= k);
                rv = (h + k <= end_pos);
                if (!lv && !rv)
                    break;
                lh = lv ? (req_count[h - k] != '0) : 1'b0;
                rh = rv ? (req_count[h + k] != '0) : 1'b0;
                if (lh && rh) begin
                    target = moving_right ? h + k : h - k;
                    found  = 1'b1;
                end else if (rh) begin
                    target       = h + k;
                    moving_right = 1'b1;
                    found        = 1'b1;
                end else if (lh) begin
                    target       = h - k;
                    moving_right = 1'b0;
                    found        = 1'b1;
                end
                if (found) begin
                    moved = k;
                    break;
                end
            end
            if (found) begin
                res.status      = STS_SERVED;
                head            = POS_W'(target);
                req_count[head] = req_count[head] - COUNT_BITS'(1);
                if (queued_total != '0)
                    queued_total = queued_total - PEND_W'(1);
                if (travel_sum > SUM_MAX - SUM_W'(moved))
                    travel_sum = SUM_MAX;
                else
                    travel_sum = travel_sum + SUM_W'(moved);
            end
        end
        res.head_position  = head;
        res.distance_moved = POS_W'(moved);
        res.total_distance = travel_sum;
        return res;
    endfunction

    task automatic report_field(input string field, input logic [SUM_W-1:0] want,
                                input logic [SUM_W-1:0] got);
        if (want !== got) begin
            miscompares++;
            if (miscompares <= MAX_REPORTS)
                $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : track_and_compare
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_POSITIONS; i++)
                req_count[i] = '0;
            head         = '0;
            moving_right = 1'b1;
            queued_total = '0;
            travel_sum   = '0;
            track_end    = TRACK_END_RST;
            awaited_outcomes.delete();
        end else begin
            if (i_cfg_we)
                track_end = i_cfg_data;
            // Compare before queuing: a request may be taken on the strobe edge.
            if (i_strobe) begin
                if (awaited_outcomes.size() == 0) begin
                    miscompares++;
                    if (miscompares <= MAX_REPORTS)
                        $display({"%0t: result with no request outstanding, ",
                                  "expected none, got status %0d head %0d"},
                                 $time, i_result.status, i_result.head_position);
                end else begin
                    want = awaited_outcomes.pop_front();
                    report_field("status", SUM_W'(want.status), SUM_W'(i_result.status));
                    report_field("head_position", SUM_W'(want.head_position),
                                 SUM_W'(i_result.head_position));
                    report_field("distance_moved", SUM_W'(want.distance_moved),
                                 SUM_W'(i_result.distance_moved));
                    report_field("total_distance", want.total_distance,
                                 i_result.total_distance);
                end
            end
            if (i_start && !i_busy)
                awaited_outcomes.push_back(schedule_request(i_req));
        end
        o_miscompares <= miscompares;
        o_awaited     <= awaited_outcomes.size();
    end

endmodule

@@ tb/sv/nearest_request_seek_scheduler_top_tb.sv @@
// Testbench top for the nearest request seek scheduler: request stimulus and verdict.
`timescale 1ns / 100ps

module nearest_request_seek_scheduler_top_tb;
    import nrss_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 12;
    // Worst case: reset clear pass and ~580 requests that could each scan the
    // whole line, plus idle; the limit allows about five times that.
    localparam int CYCLE_LIMIT   = 3_000_000;
    // Longest single request is an empty serve on the full line.
    localparam int SETTLE_CYCLES = NUM_POSITIONS + 8;
    localparam int PHASE_REQS    = 110;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_req              i_req;
    logic              i_cfg_we;
    logic [POS_W-1:0]  i_cfg_data;
    logic              o_strobe;
    t_result           o_result;

    int                miscompares;
    int                awaited;
    logic [POS_W-1:0]  last_head = '0;      // head as last reported, steers near-head requests
    logic [POS_W-1:0]  cur_track_end;
    bit                idle_on;

    nearest_request_seek_scheduler_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

    nearest_request_seek_scheduler_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_req         (i_req),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_strobe      (o_strobe),
        .i_result      (o_result),
        .o_miscompares (miscompares),
        .o_awaited     (awaited)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Hard stop if the block hangs.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("nearest_request_seek_scheduler_top: mismatch");
        $finish;
    end

    always @(posedge i_clk) begin
        if (o_strobe)
            last_head <= o_result.head_position;
    end

    // One request: optional idle burst, then hold start until the block takes it.
    // Start stays high into the next request when no gap follows.
    task automatic issue(input logic op, input int pos);
        t_req req;
        req.op       = op;
        req.position = POS_W'(pos);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                @(negedge i_clk);
                start <= 1'b0;
            end
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (busy);
    endtask

    // Stop sending and wait for every outstanding result.
    task automatic wait_all_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (awaited != 0) @(posedge i_clk);
    endtask

    // track_end only changes with nothing in flight.
    task automatic set_track_end(input logic [POS_W-1:0] value);
        wait_all_results();
        @(negedge i_clk);
        i_cfg_we      <= 1'b1;
        i_cfg_data    <= value;
        cur_track_end  = value;
        @(negedge i_clk);
        i_cfg_we      <= 1'b0;
    endtask

    // Mixed adds and serves. Many adds land near the head so ties and short
    // seeks are common; some go anywhere on the line, a few past track_end.
    // Serve positions are random too, the block must ignore them.
    task automatic run_random_phase(input int count);
        int   pos;
        logic op;
        for (int i = 0; i < count; i++) begin
            if (idle_on && i == count / 2)
                wait_all_results();      // let the block run dry mid-phase
            op = ($urandom_range(0, 99) < 45) ? OP_SERVE : OP_ADD;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: pos = int'(last_head) + int'($urandom_range(0, 32)) - 16;
                9:          pos = int'($urandom_range(0, NUM_POSITIONS - 1));
                default:    pos = int'($urandom_range(0, cur_track_end));
            endcase
            if (pos < 0)
                pos = 0;
            else if (pos > NUM_POSITIONS - 1)
                pos = NUM_POSITIONS - 1;
            issue(op, pos);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_req         = '0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        cur_track_end = TRACK_END_RST;
        idle_on       = 1'b1;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---- Directed, full line (track_end at reset value) ----
        issue(OP_SERVE, 0);          // nothing pending: status empty, head stays 0
        issue(OP_ADD, 0);
        issue(OP_ADD, 10);
        issue(OP_ADD, 20);
        issue(OP_ADD, 1023);
        issue(OP_SERVE, 0);          // request under the head: distance 0, still moving right
        issue(OP_SERVE, 0);          // right to 10
        issue(OP_ADD, 0);
        issue(OP_SERVE, 0);          // 0 and 20 both 10 away: tie goes right to 20
        issue(OP_SERVE, 0);          // left to 0, direction now left
        issue(OP_SERVE, 0);          // full line seek, 0 to 1023
        issue(OP_SERVE, 0);          // empty again at the far end
        issue(OP_ADD, 1013);
        issue(OP_SERVE, 0);          // left to 1013
        issue(OP_ADD, 1003);
        issue(OP_ADD, 1023);
        issue(OP_SERVE, 0);          // tie while moving left: goes to 1003
        issue(OP_SERVE, 0);          // right to 1023
        issue(OP_ADD, 700);

        // ---- Shortest line, head and a request left above it ----
        set_track_end(POS_W'(1));
        issue(OP_ADD, 2);            // just past the line: rejected
        issue(OP_ADD, 1023);         // far past the line: rejected
        issue(OP_ADD, 1);
        issue(OP_ADD, 0);
        issue(OP_SERVE, 0);          // head above the line scans left only, finds 700
        issue(OP_SERVE, 0);          // on to 1
        issue(OP_SERVE, 0);          // then 0
        issue(OP_SERVE, 0);          // nothing left on the short line

        // ---- Random phases over several line lengths ----
        set_track_end(TRACK_END_RST);
        run_random_phase(PHASE_REQS);
        set_track_end(POS_W'(63));
        run_random_phase(PHASE_REQS);
        set_track_end(POS_W'($urandom_range(2, 1022)));
        run_random_phase(PHASE_REQS);
        set_track_end(POS_W'(1));
        run_random_phase(PHASE_REQS);
        set_track_end(TRACK_END_RST);
        idle_on = 1'b0;              // closing stretch back to back
        run_random_phase(PHASE_REQS);

        // Drain, then leave room for any stray result.
        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (miscompares == 0)
            $display("nearest_request_seek_scheduler_top: match");
        else
            $display("nearest_request_seek_scheduler_top: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/nrss_pkg.sv
rtl/core/nrss_ram.sv
rtl/core/nrss_ctrl.sv
rtl/core/nrss_dpath.sv
rtl/core/nearest_request_seek_scheduler_top.sv
rtl/core/nrss_checker.sv
tb/sv/nearest_request_seek_scheduler_checker.sv
tb/sv/nearest_request_seek_scheduler_top_tb.sv
